@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the checker file of this block.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define BBPE_ASSERT(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
        else $error(msg);

// Clocked assertion that is checked in reset as well.
`define BBPE_ASSERT_ALWAYS(lbl, ck, prop, msg) \
    lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

@@ hw/rtl/bbpe_pkg.sv @@
// Types and fixed constants of the bicubic Bezier patch evaluator.
// Depends on nothing; used by the top level and its checker.
`timescale 1ns / 1ps

package bbpe_pkg;

    localparam int COORD_W  = 16;
    localparam int TEX_W    = 17;
    localparam int CFG_W    = 7;
    localparam int IDX_W    = 6;
    localparam int CP_DEPTH = 16;
    localparam int CP_W     = 3 * COORD_W;
    localparam int QUO_W    = 18;
    localparam int LANES    = 5;

    localparam logic [CFG_W-1:0] GRID_RESET = 7'd10;
    localparam logic [TEX_W-1:0] TEX_ONE    = 17'd65536;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [TEX_W-1:0] tex_t;

endpackage

@@ hw/rtl/bicubic_bezier_patch_eval.sv @@
// Bicubic Bezier patch evaluator: control point store, weight unit,
// accumulator and a five-lane restoring divider. Depends on bbpe_pkg.
`timescale 1ns / 1ps

// Usage:
// The request channel (in_valid / in_stall) carries either a control point
// load (func = 0) or a grid evaluation (func = 1). A load writes the 4x4 store
// at the edge it is taken, so loads can follow each other with no gap.
// An evaluation forms the Bernstein weights in W1, W2 and W3, streams the 16
// control points out of the store and accumulates them (ACC), sets up the
// divider (DINIT), runs the five-lane restoring divider (DIV, one quotient
// bit per cycle in each lane) and fills the output register (FIN). A new
// request is taken only once the last result is in the output register.
// A grid index at or above the density (capped at MAX_GRID) skips to FIN.
// in_stall stays high while an evaluation is in flight.
// Results sit in an output register (out_valid / out_stall); a stalled result
// holds, and loads are still taken while it waits. A finished evaluation waits
// in its last step until the output register is free.
// The density register is written over cfg_valid / cfg_ready; the user writes
// it only while idle, and the block itself does not enforce this.
// Reset clears the control state and sets the density to 10; the store is not
// cleared, so every control point must be loaded before it is used.
module bicubic_bezier_patch_eval
    import bbpe_pkg::*;
#(
    parameter int MAX_GRID = 64
)
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    func,
    input  logic [1:0]              ctrl_row,
    input  logic [1:0]              ctrl_col,
    input  logic signed [COORD_W-1:0] point_x,
    input  logic signed [COORD_W-1:0] point_y,
    input  logic signed [COORD_W-1:0] point_z,
    input  logic [IDX_W-1:0]        grid_u_index,
    input  logic [IDX_W-1:0]        grid_v_index,

    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [COORD_W-1:0] vert_x,
    output logic signed [COORD_W-1:0] vert_y,
    output logic signed [COORD_W-1:0] vert_z,
    output logic [TEX_W-1:0]        tex_u,
    output logic [TEX_W-1:0]        tex_v,
    output logic                    index_error,

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_W-1:0]        cfg_data
);

    localparam int DW = (MAX_GRID > 2) ? $clog2(MAX_GRID) : 1;
    localparam int W3 = 3 * DW;
    localparam int W6 = 6 * DW;
    localparam int SW = W3 + 17;
    localparam int AW = W6 + 18;
    localparam int RW = AW + 2;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_W1    = 3'd1;
    localparam logic [2:0] ST_W2    = 3'd2;
    localparam logic [2:0] ST_W3    = 3'd3;
    localparam logic [2:0] ST_ACC   = 3'd4;
    localparam logic [2:0] ST_DINIT = 3'd5;
    localparam logic [2:0] ST_DIV   = 3'd6;
    localparam logic [2:0] ST_FIN   = 3'd7;

    localparam logic [4:0] ACC_LAST = 5'd17;
    localparam logic [4:0] DIV_LAST = 5'(QUO_W - 1);

    logic [2:0]        state_reg, state_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic [CFG_W-1:0]  grid_reg;
    logic              out_valid_reg;
    logic              rd_vld_reg;
    logic              row_done_reg;

    logic [CP_W-1:0]   cp_mem [CP_DEPTH];
    logic [CP_W-1:0]   rd_data_reg;
    logic [3:0]        rd_idx_reg;
    logic [1:0]        row_reg;

    logic [DW-1:0]     d_reg, tu_reg, tv_reg, su_reg, sv_reg;
    logic [DW+1:0]     tu3_reg, tv3_reg, su3_reg, sv3_reg;
    logic [2*DW-1:0]   tu2_reg, tv2_reg, su2_reg, sv2_reg, d2_reg;
    logic [W3-1:0]     wu_reg [4];
    logic [W3-1:0]     wv_reg [4];
    logic [W3-1:0]     d3_reg;
    logic [W6-1:0]     den_reg;
    logic              err_reg;

    logic signed [SW-1:0] s_reg   [3];
    logic signed [AW-1:0] acc_reg [3];
    logic signed [SW-1:0] prod_v  [3];
    logic signed [AW-1:0] prod_u  [3];

    logic [RW-1:0]     rem_reg [LANES];
    logic [RW-1:0]     dsh_reg [LANES];
    logic [QUO_W-1:0]  q_reg   [LANES];
    logic              neg_reg [LANES];

    logic [RW-1:0]     init_mag [LANES];
    logic [RW-1:0]     init_dsh [LANES];
    logic              init_neg [LANES];
    coord_t            res_coord [3];

    coord_t            vert_x_reg, vert_y_reg, vert_z_reg;
    tex_t              tex_u_reg, tex_v_reg;
    logic              index_error_reg;

    logic              in_fire, load_fire, eval_fire, out_fire, fin_fire;
    logic [CFG_W-1:0]  n_eff, d_sel;
    logic              idx_err;

    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && !in_stall;
    assign load_fire = in_fire && (func == FUNC_LOAD);
    assign eval_fire = in_fire && (func == FUNC_EVAL);
    assign out_fire  = out_valid_reg && !out_stall;
    assign fin_fire  = (state_reg == ST_FIN) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        if (int'(grid_reg) > MAX_GRID)
            n_eff = CFG_W'(MAX_GRID);
        else
            n_eff = grid_reg;
        idx_err = (CFG_W'(grid_u_index) >= n_eff) || (CFG_W'(grid_v_index) >= n_eff);
        // A density of one behaves as a span of one with the index at zero.
        d_sel = (n_eff <= CFG_W'(1)) ? CFG_W'(1) : n_eff - CFG_W'(1);
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (eval_fire)
                    state_next = idx_err ? ST_FIN : ST_W1;
            end
            ST_W1: state_next = ST_W2;
            ST_W2: state_next = ST_W3;
            ST_W3:
            begin
                state_next = ST_ACC;
                cnt_next   = '0;
            end
            ST_ACC:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == ACC_LAST)
                    state_next = ST_DINIT;
            end
            ST_DINIT:
            begin
                state_next = ST_DIV;
                cnt_next   = '0;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == DIV_LAST)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (fin_fire)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            grid_reg      <= GRID_RESET;
            out_valid_reg <= 1'b0;
            rd_vld_reg    <= 1'b0;
            row_done_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            rd_vld_reg   <= (state_reg == ST_ACC) && !cnt_reg[4];
            row_done_reg <= rd_vld_reg && (rd_idx_reg[1:0] == 2'd3);
            if (cfg_valid && cfg_ready)
                grid_reg <= cfg_data;
            if (fin_fire)
                out_valid_reg <= 1'b1;
            else if (out_fire)
                out_valid_reg <= 1'b0;
        end
    end

    // Control point store: one write port for loads, one registered read port.
    always_ff @(posedge clk)
    begin
        if (load_fire)
            cp_mem[{ctrl_row, ctrl_col}] <= {point_z, point_y, point_x};
        rd_data_reg <= cp_mem[cnt_reg[3:0]];
        rd_idx_reg  <= cnt_reg[3:0];
        row_reg     <= rd_idx_reg[3:2];
    end

    // Full-width products for the row sums and for the weighting of each row.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            prod_v[k] = $signed({1'b0, wv_reg[rd_idx_reg[1:0]]})
                * $signed(rd_data_reg[k*COORD_W +: COORD_W]);
            prod_u[k] = $signed({1'b0, wu_reg[row_reg]}) * s_reg[k];
        end
    end

    // Divider lane setup: coordinates divide 2*acc + den by 2*den,
    // texture lanes divide 2*65536*t + d by 2*d.
    always_comb
    begin
        logic signed [AW+1:0] a_s;
        for (int k = 0; k < 3; k++)
        begin
            a_s = $signed({acc_reg[k][AW-1], acc_reg[k], 1'b0})
                + $signed((AW+2)'(den_reg));
            init_neg[k] = a_s[AW+1];
            init_mag[k] = RW'(a_s[AW+1] ? -a_s : a_s);
            init_dsh[k] = RW'(den_reg) << QUO_W;
        end
        init_neg[3] = 1'b0;
        init_neg[4] = 1'b0;
        init_mag[3] = (RW'(tu_reg) << 17) + RW'(d_reg);
        init_mag[4] = (RW'(tv_reg) << 17) + RW'(d_reg);
        init_dsh[3] = RW'(d_reg) << QUO_W;
        init_dsh[4] = RW'(d_reg) << QUO_W;
    end

    // Floor of the quotient, then saturation to the coordinate range.
    always_comb
    begin
        logic [QUO_W:0]         qq;
        logic signed [QUO_W+1:0] v;
        for (int k = 0; k < 3; k++)
        begin
            qq = {1'b0, q_reg[k]} + (QUO_W+1)'(neg_reg[k] && (rem_reg[k] != '0));
            v  = $signed({1'b0, qq});
            if (neg_reg[k])
                v = -v;
            if (v > 32767)
                res_coord[k] = 16'sh7FFF;
            else if (v < -32768)
                res_coord[k] = 16'sh8000;
            else
                res_coord[k] = v[COORD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (eval_fire)
        begin
            err_reg <= idx_err;
            d_reg   <= DW'(d_sel);
            tu_reg  <= DW'(grid_u_index);
            tv_reg  <= DW'(grid_v_index);
            su_reg  <= DW'(d_sel) - DW'(grid_u_index);
            sv_reg  <= DW'(d_sel) - DW'(grid_v_index);
        end
        if (state_reg == ST_W1)
        begin
            su2_reg <= su_reg * su_reg;
            tu2_reg <= tu_reg * tu_reg;
            sv2_reg <= sv_reg * sv_reg;
            tv2_reg <= tv_reg * tv_reg;
            d2_reg  <= d_reg * d_reg;
            su3_reg <= (DW+2)'(su_reg) * (DW+2)'(3);
            tu3_reg <= (DW+2)'(tu_reg) * (DW+2)'(3);
            sv3_reg <= (DW+2)'(sv_reg) * (DW+2)'(3);
            tv3_reg <= (DW+2)'(tv_reg) * (DW+2)'(3);
        end
        if (state_reg == ST_W2)
        begin
            wu_reg[0] <= W3'(su2_reg) * W3'(su_reg);
            wu_reg[1] <= W3'(su2_reg) * W3'(tu3_reg);
            wu_reg[2] <= W3'(su3_reg) * W3'(tu2_reg);
            wu_reg[3] <= W3'(tu2_reg) * W3'(tu_reg);
            wv_reg[0] <= W3'(sv2_reg) * W3'(sv_reg);
            wv_reg[1] <= W3'(sv2_reg) * W3'(tv3_reg);
            wv_reg[2] <= W3'(sv3_reg) * W3'(tv2_reg);
            wv_reg[3] <= W3'(tv2_reg) * W3'(tv_reg);
            d3_reg    <= W3'(d2_reg) * W3'(d_reg);
        end
        if (state_reg == ST_W3)
        begin
            den_reg <= W6'(d3_reg) * W6'(d3_reg);
            for (int k = 0; k < 3; k++)
                acc_reg[k] <= '0;
        end
        // Row sums along v, then one weighted add along u per finished row.
        if (rd_vld_reg)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s_reg[k] <= ((rd_idx_reg[1:0] == 2'd0) ? SW'(0) : s_reg[k])
                    + prod_v[k];
            end
        end
        if (row_done_reg)
        begin
            for (int k = 0; k < 3; k++)
                acc_reg[k] <= acc_reg[k] + prod_u[k];
        end
        if (state_reg == ST_DINIT)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                rem_reg[k] <= init_mag[k];
                dsh_reg[k] <= init_dsh[k];
                neg_reg[k] <= init_neg[k];
                q_reg[k]   <= '0;
            end
        end
        if (state_reg == ST_DIV)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                if (rem_reg[k] >= dsh_reg[k])
                begin
                    rem_reg[k] <= rem_reg[k] - dsh_reg[k];
                    q_reg[k]   <= {q_reg[k][QUO_W-2:0], 1'b1};
                end
                else
                    q_reg[k]   <= {q_reg[k][QUO_W-2:0], 1'b0};
                dsh_reg[k] <= dsh_reg[k] >> 1;
            end
        end
        if (fin_fire)
        begin
            index_error_reg <= err_reg;
            if (err_reg)
            begin
                vert_x_reg <= '0;
                vert_y_reg <= '0;
                vert_z_reg <= '0;
                tex_u_reg  <= '0;
                tex_v_reg  <= '0;
            end
            else
            begin
                vert_x_reg <= res_coord[0];
                vert_y_reg <= res_coord[1];
                vert_z_reg <= res_coord[2];
                tex_u_reg  <= q_reg[3][TEX_W-1:0];
                tex_v_reg  <= q_reg[4][TEX_W-1:0];
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign vert_x      = vert_x_reg;
    assign vert_y      = vert_y_reg;
    assign vert_z      = vert_z_reg;
    assign tex_u       = tex_u_reg;
    assign tex_v       = tex_v_reg;
    assign index_error = index_error_reg;

endmodule

@@ hw/rtl/bbpe_checker.sv @@
// Port-level checker for the Bezier patch evaluator, bound to the top level.
// Depends on bbpe_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bbpe_assert_checker
    import bbpe_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_stall,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic signed [COORD_W-1:0] vert_x,
    input logic signed [COORD_W-1:0] vert_y,
    input logic signed [COORD_W-1:0] vert_z,
    input logic [TEX_W-1:0]          tex_u,
    input logic [TEX_W-1:0]          tex_v,
    input logic                      index_error
);

    // A stalled result holds.
    `BBPE_ASSERT(a_out_hold, clk, rst_n,
        out_valid && out_stall |=> out_valid && $stable(vert_x) && $stable(vert_y)
            && $stable(vert_z) && $stable(tex_u) && $stable(tex_v)
            && $stable(index_error),
        "stalled result changed")

    // An out-of-range request reports all zeros.
    `BBPE_ASSERT(a_err_zero, clk, rst_n,
        out_valid && index_error |-> vert_x == 0 && vert_y == 0 && vert_z == 0
            && tex_u == 0 && tex_v == 0,
        "error result not zero")

    // Parameters never exceed one.
    `BBPE_ASSERT(a_tex_range, clk, rst_n, out_valid |-> tex_u <= TEX_ONE && tex_v <= TEX_ONE, "texture parameter above one")

    // The block only leaves an evaluation by handing over its result.
    `BBPE_ASSERT(a_busy_ends, clk, rst_n, $fell(in_stall) |-> out_valid, "evaluation ended without result")

endmodule

bind bicubic_bezier_patch_eval bbpe_assert_checker u_bbpe_checker (.*);
